/* hdl/levenshtein_edit_distance_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the edit distance block
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LEVENSHTEIN_EDIT_DISTANCE_DEFINES_SVH
`define LEVENSHTEIN_EDIT_DISTANCE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LED_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("edit distance check failed");

// next-cycle implication
`define LED_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("edit distance check failed");

`else

`define LED_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LED_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/led_pkg.sv */
// ----------------------------------------------------------------------------
// led_pkg
// Shared constants and the token control type of the edit distance array.
// ----------------------------------------------------------------------------
package led_pkg;

	// default configuration
	localparam int MAX_PATTERN_DEF = 64;
	localparam int COST_BITS_DEF   = 16;

	// fixed field widths
	localparam int SYM_BITS  = 8;
	localparam int DIST_BITS = 16;

	// request kinds carried by the mode field
	localparam logic MODE_PATTERN = 1'b0;
	localparam logic MODE_TEXT    = 1'b1;

	// control part of a token walking down the cell chain
	typedef struct packed {
		logic                valid;   // token present
		logic                is_text; // text byte, else pattern byte
		logic                init;    // text start: row restarts at 0..m
		logic                last;    // text end: deliver distance
		logic                wr;      // pattern byte to be stored
		logic                ovf;     // pattern overflow seen at entry
		logic [SYM_BITS-1:0] sym;     // byte carried
	} led_ctl_t;

endpackage

/* hdl/led_cell.sv */
// ----------------------------------------------------------------------------
// led_cell
// One column of the cost row: holds a pattern byte and its cost, and updates
// the cost as each text token that reaches its column passes to the next cell.
// ----------------------------------------------------------------------------
module led_cell import led_pkg::*; #(
	parameter int COL       = 1,
	parameter int POS_BITS  = 7,
	parameter int COST_BITS = COST_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  led_ctl_t             ctl_in,
	input  logic [POS_BITS-1:0]  pos_in,
	input  logic [COST_BITS-1:0] diag_in,
	input  logic [COST_BITS-1:0] left_in,
	output led_ctl_t             ctl_out,
	output logic [POS_BITS-1:0]  pos_out,
	output logic [COST_BITS-1:0] diag_out,
	output logic [COST_BITS-1:0] left_out
);

	localparam longint unsigned CostMax = (64'd1 << COST_BITS) - 64'd1;
	localparam logic [COST_BITS-1:0] InitCost =
		COST_BITS'((64'(COL) > CostMax) ? CostMax : 64'(COL));

	function automatic logic [COST_BITS-1:0] sat_inc(input logic [COST_BITS-1:0] v,
			input logic d);
		return (d && (v != {COST_BITS{1'b1}})) ? v + COST_BITS'(1) : v;
	endfunction

	led_ctl_t             ctl_q;
	logic [POS_BITS-1:0]  pos_q;
	logic [COST_BITS-1:0] diag_q;
	logic [COST_BITS-1:0] left_q;
	logic [COST_BITS-1:0] cost_q;
	logic [SYM_BITS-1:0]  sym_q;

	logic                 in_row;
	logic                 hit;
	logic [COST_BITS-1:0] above;
	logic [COST_BITS-1:0] c_diag;
	logic [COST_BITS-1:0] c_ins;
	logic [COST_BITS-1:0] c_del;
	logic [COST_BITS-1:0] best;

	// cell update: minimum of substitute, insert and delete
	always_comb begin
		in_row = (pos_in >= POS_BITS'(COL));
		hit    = ctl_in.valid && ctl_in.is_text && in_row;
		above  = ctl_in.init ? InitCost : cost_q;
		c_diag = sat_inc(diag_in, sym_q != ctl_in.sym);
		c_ins  = sat_inc(left_in, 1'b1);
		c_del  = sat_inc(above, 1'b1);
		best   = c_diag;
		if (c_ins < best) begin
			best = c_ins;
		end
		if (c_del < best) begin
			best = c_del;
		end
	end

	// token stage toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_q  <= pos_in;
			diag_q <= above;
			left_q <= hit ? best : left_in;
		end
	end

	// column cost
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_q <= '0;
		end else if (adv && hit) begin
			cost_q <= best;
		end
	end

	// stored pattern byte, loaded when its write token passes
	always_ff @(posedge clk) begin
		if (adv && ctl_in.valid && !ctl_in.is_text && ctl_in.wr &&
				pos_in == POS_BITS'(COL - 1)) begin
			sym_q <= ctl_in.sym;
		end
	end

	assign ctl_out  = ctl_q;
	assign pos_out  = pos_q;
	assign diag_out = diag_q;
	assign left_out = left_q;

endmodule

/* hdl/led_head.sv */
// ----------------------------------------------------------------------------
// led_head
// Entry of the chain: tracks pattern length and overflow, holds column zero,
// and launches one token per accepted request.
// ----------------------------------------------------------------------------
module led_head import led_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int POS_BITS    = 7,
	parameter int COST_BITS   = COST_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  logic                 mode,
	input  logic [SYM_BITS-1:0]  symbol,
	input  logic                 first,
	input  logic                 last,
	output led_ctl_t             ctl_out,
	output logic [POS_BITS-1:0]  pos_out,
	output logic [COST_BITS-1:0] diag_out,
	output logic [COST_BITS-1:0] left_out
);

	logic [POS_BITS-1:0]  len_q;
	logic                 ovf_q;
	logic [COST_BITS-1:0] cost0_q;

	led_ctl_t             ctl_q;
	logic [POS_BITS-1:0]  pos_q;
	logic [COST_BITS-1:0] diag_q;
	logic [COST_BITS-1:0] left_q;

	logic                 accept;
	logic [POS_BITS-1:0]  base_len;
	logic                 base_ovf;
	logic                 room;
	logic [COST_BITS-1:0] above0;
	logic [COST_BITS-1:0] new0;
	led_ctl_t             ctl_d;
	logic [POS_BITS-1:0]  pos_d;

	// pattern bookkeeping and column zero
	always_comb begin
		accept   = in_valid && adv;
		base_len = first ? '0 : len_q;
		base_ovf = first ? 1'b0 : ovf_q;
		room     = (base_len < POS_BITS'(MAX_PATTERN));
		above0   = first ? '0 : cost0_q;
		new0     = (above0 != {COST_BITS{1'b1}}) ? above0 + COST_BITS'(1) : above0;

		ctl_d.valid   = in_valid;
		ctl_d.is_text = (mode == MODE_TEXT);
		ctl_d.init    = first;
		ctl_d.last    = last;
		ctl_d.wr      = room;
		ctl_d.ovf     = ovf_q;
		ctl_d.sym     = symbol;
		pos_d         = (mode == MODE_TEXT) ? len_q : base_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			ovf_q   <= 1'b0;
			cost0_q <= '0;
		end else if (accept) begin
			if (mode == MODE_TEXT) begin
				cost0_q <= new0;
			end else if (room) begin
				len_q <= base_len + POS_BITS'(1);
				ovf_q <= base_ovf;
			end else begin
				len_q <= base_len;
				ovf_q <= 1'b1;
			end
		end
	end

	// token register feeding cell one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_q  <= pos_d;
			diag_q <= above0;
			left_q <= new0;
		end
	end

	assign ctl_out  = ctl_q;
	assign pos_out  = pos_q;
	assign diag_out = diag_q;
	assign left_out = left_q;

endmodule

/* hdl/levenshtein_edit_distance.sv */
// ----------------------------------------------------------------------------
// levenshtein_edit_distance: edit distance of a streamed text to a stored pattern
// A text request with last returns its distance once its token has passed the head
// register, the chain of MAX_PATTERN cells and the result register.
// Throughput: one request per cycle, pattern or text, while out_ready keeps up.
// Reset clears pattern length, overflow flag, all column costs and the chain tokens.
// ----------------------------------------------------------------------------
`include "levenshtein_edit_distance_defines.svh"

module levenshtein_edit_distance import led_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int COST_BITS   = COST_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 mode,
	input  logic [SYM_BITS-1:0]  symbol,
	input  logic                 first,
	input  logic                 last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DIST_BITS-1:0] distance,
	output logic                 overflow
);

	localparam int POS_BITS = $clog2(MAX_PATTERN + 1);

	// token chain: index 0 is the head, index MAX_PATTERN the tail
	led_ctl_t             ctl_c  [0:MAX_PATTERN];
	logic [POS_BITS-1:0]  pos_c  [0:MAX_PATTERN];
	logic [COST_BITS-1:0] diag_c [0:MAX_PATTERN];
	logic [COST_BITS-1:0] left_c [0:MAX_PATTERN];

	logic                 adv;
	logic                 out_valid_q;
	logic [DIST_BITS-1:0] distance_q;
	logic                 overflow_q;
	logic [DIST_BITS-1:0] dist_sat;
	logic                 tail_result;

	// whole chain moves unless a result is waiting to be taken
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	led_head #(
		.MAX_PATTERN (MAX_PATTERN),
		.POS_BITS    (POS_BITS),
		.COST_BITS   (COST_BITS)
	) u_head (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.mode     (mode),
		.symbol   (symbol),
		.first    (first),
		.last     (last),
		.ctl_out  (ctl_c[0]),
		.pos_out  (pos_c[0]),
		.diag_out (diag_c[0]),
		.left_out (left_c[0])
	);

	for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
		led_cell #(
			.COL       (j),
			.POS_BITS  (POS_BITS),
			.COST_BITS (COST_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.ctl_in   (ctl_c[j-1]),
			.pos_in   (pos_c[j-1]),
			.diag_in  (diag_c[j-1]),
			.left_in  (left_c[j-1]),
			.ctl_out  (ctl_c[j]),
			.pos_out  (pos_c[j]),
			.diag_out (diag_c[j]),
			.left_out (left_c[j])
		);
	end

	// cells past the pattern pass left through, so the tail holds cost of column m
	if (COST_BITS > DIST_BITS) begin : g_sat
		assign dist_sat = (|left_c[MAX_PATTERN][COST_BITS-1:DIST_BITS]) ?
			{DIST_BITS{1'b1}} : left_c[MAX_PATTERN][DIST_BITS-1:0];
	end else begin : g_ext
		assign dist_sat = DIST_BITS'(left_c[MAX_PATTERN]);
	end

	assign tail_result = ctl_c[MAX_PATTERN].valid && ctl_c[MAX_PATTERN].is_text &&
		ctl_c[MAX_PATTERN].last;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= tail_result;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			distance_q <= dist_sat;
			overflow_q <= ctl_c[MAX_PATTERN].ovf;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = distance_q;
	assign overflow  = overflow_q;

	// a stall freezes the token entering the chain
	`LED_ASSERT_NXT(a_stall_holds_head, clk, arst_n, !adv, $stable(ctl_c[0]))
	// a finished text token always yields a result
	`LED_ASSERT_NXT(a_tail_gives_result, clk, arst_n, adv && tail_result, out_valid)
	// a new result comes only from a text token with last at the tail
	`LED_ASSERT_IMP(a_result_source, clk, arst_n, $rose(out_valid), $past(tail_result))

endmodule

/* bench/levenshtein_edit_distance_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// levenshtein_edit_distance_test: self-checking bench for the edit distance block
// Streams pattern and text requests, tracks the DP cost row alongside the block
// and compares every returned distance and overflow flag in order.
// ----------------------------------------------------------------------------
module levenshtein_edit_distance_test;
	import led_pkg::*;

	localparam int PAT_CAP     = MAX_PATTERN_DEF;
	localparam int COST_LIMIT  = (1 << COST_BITS_DEF) - 1;
	localparam int DIST_LIMIT  = (1 << DIST_BITS) - 1;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic [DIST_BITS-1:0] distance;
		logic                 overflow;
	} dist_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 mode;
	logic [SYM_BITS-1:0]  symbol;
	logic                 first;
	logic                 last;
	logic                 out_valid;
	logic                 out_ready;
	logic [DIST_BITS-1:0] distance;
	logic                 overflow;

	// tracked block state
	logic [SYM_BITS-1:0] pat_bytes [PAT_CAP];
	int                  pat_len;
	logic                pat_ovf;
	int                  row_cost [PAT_CAP+1];

	dist_result_t expected_distances [$];
	dist_result_t want;

	int items_sent;
	int results_checked = 0;
	int ovf_results = 0;
	int mismatches = 0;
	int stalled_cycles;
	int in_gap_pct;
	int out_stall_pct;

	levenshtein_edit_distance #(
		.MAX_PATTERN(MAX_PATTERN_DEF),
		.COST_BITS(COST_BITS_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.symbol(symbol),
		.first(first),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.distance(distance),
		.overflow(overflow)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int sat_add(int v, int d);
		return (v + d > COST_LIMIT) ? COST_LIMIT : v + d;
	endfunction

	// advance the tracked state by one request, queue the distance on text end
	function automatic void predict_distance(logic md, logic [SYM_BITS-1:0] sym,
			logic fst, logic lst);
		int m;
		int diag;
		int left;
		int above;
		int best;
		dist_result_t r;
		if (md == MODE_PATTERN) begin
			if (fst) begin
				pat_len = 0;
				pat_ovf = 1'b0;
			end
			if (pat_len < PAT_CAP) begin
				pat_bytes[pat_len] = sym;
				pat_len++;
			end else begin
				pat_ovf = 1'b1;
			end
			return;
		end
		m = pat_len;
		if (fst) begin
			for (int j = 0; j <= m; j++)
				row_cost[j] = sat_add(j, 0);
		end
		diag = row_cost[0];
		left = sat_add(row_cost[0], 1);
		row_cost[0] = left;
		for (int j = 1; j <= m; j++) begin
			above = row_cost[j];
			best = sat_add(diag, (pat_bytes[j-1] == sym) ? 0 : 1);
			if (sat_add(left, 1) < best)
				best = sat_add(left, 1);
			if (sat_add(above, 1) < best)
				best = sat_add(above, 1);
			row_cost[j] = best;
			diag = above;
			left = best;
		end
		if (lst) begin
			r.distance = DIST_BITS'((row_cost[m] > DIST_LIMIT) ? DIST_LIMIT : row_cost[m]);
			r.overflow = pat_ovf;
			expected_distances.push_back(r);
		end
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= 25)
			$display("ERROR %0t: %s", $time, msg);
	endtask

	// one request: optional idle burst, then hold valid until accepted
	task automatic send_request(logic md, logic [SYM_BITS-1:0] sym, logic fst, logic lst);
		int gap;
		if ($urandom_range(0, 99) < in_gap_pct) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= md;
		symbol   <= sym;
		first    <= fst;
		last     <= lst;
		do @(posedge clk); while (!in_ready);
		predict_distance(md, sym, fst, lst);
		items_sent++;
	endtask

	// output side back-pressure in bursts
	initial begin
		int n;
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (arst_n && $urandom_range(0, 99) < out_stall_pct) begin
				n = $urandom_range(1, 8);
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// result check, in order
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_distances.size() == 0) begin
				report_mismatch($sformatf("unexpected result distance=%0d overflow=%0b",
					distance, overflow));
			end else begin
				want = expected_distances.pop_front();
				results_checked++;
				if (want.overflow)
					ovf_results++;
				if (distance !== want.distance)
					report_mismatch($sformatf("distance %0d, expected %0d",
						distance, want.distance));
				if (overflow !== want.overflow)
					report_mismatch($sformatf("overflow %0b, expected %0b",
						overflow, want.overflow));
			end
		end
	end

	// watchdog: too long without any request or result moving
	initial begin
		stalled_cycles = 0;
		while (stalled_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				stalled_cycles = 0;
			else
				stalled_cycles++;
		end
		$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
		$display("levenshtein_edit_distance: mismatch");
		$finish;
	end

	// extremes, empty pattern, ignored last, restart, continue, mid-text pattern change
	task automatic test_directed();
		in_gap_pct    = 20;
		out_stall_pct = 20;
		send_request(MODE_TEXT, 8'h00, 1'b0, 1'b1);
		send_request(MODE_TEXT, 8'hFF, 1'b1, 1'b0);
		send_request(MODE_TEXT, 8'h80, 1'b0, 1'b1);
		send_request(MODE_PATTERN, 8'hFF, 1'b1, 1'b1);
		send_request(MODE_PATTERN, 8'h00, 1'b0, 1'b0);
		send_request(MODE_PATTERN, 8'h7F, 1'b0, 1'b0);
		send_request(MODE_TEXT, 8'hFF, 1'b1, 1'b0);
		send_request(MODE_TEXT, 8'h00, 1'b0, 1'b0);
		send_request(MODE_TEXT, 8'h7F, 1'b0, 1'b1);
		send_request(MODE_TEXT, 8'h01, 1'b1, 1'b1);
		send_request(MODE_TEXT, 8'h00, 1'b1, 1'b1);
		send_request(MODE_TEXT, 8'hFF, 1'b0, 1'b1);
		send_request(MODE_TEXT, 8'hFF, 1'b1, 1'b0);
		send_request(MODE_PATTERN, 8'h55, 1'b0, 1'b0);
		send_request(MODE_TEXT, 8'h00, 1'b0, 1'b0);
		send_request(MODE_TEXT, 8'h7F, 1'b0, 1'b0);
		send_request(MODE_TEXT, 8'h55, 1'b0, 1'b1);
		send_request(MODE_PATTERN, 8'h80, 1'b1, 1'b0);
		send_request(MODE_TEXT, 8'h80, 1'b1, 1'b1);
	endtask

	// fill the store exactly, overrun it, then clear the flag with a new pattern
	task automatic test_pattern_full();
		logic [SYM_BITS-1:0] fill [PAT_CAP];
		in_gap_pct    = 15;
		out_stall_pct = 15;
		for (int k = 0; k < PAT_CAP; k++) begin
			fill[k] = SYM_BITS'($urandom_range(0, 255));
			send_request(MODE_PATTERN, fill[k], k == 0, 1'b0);
		end
		for (int k = 0; k < PAT_CAP; k++)
			send_request(MODE_TEXT, fill[k], k == 0, k == PAT_CAP - 1);
		send_request(MODE_PATTERN, 8'hA5, 1'b0, 1'b0);
		send_request(MODE_PATTERN, 8'h5A, 1'b0, 1'b1);
		for (int k = 0; k < 3; k++)
			send_request(MODE_TEXT, fill[k], k == 0, k == 2);
		send_request(MODE_PATTERN, 8'h3C, 1'b1, 1'b0);
		send_request(MODE_TEXT, 8'h3C, 1'b1, 1'b1);
	endtask

	// pattern then text sequences with random content, plus noise and broken ones
	task automatic test_random_sequences(int n_items, bit allow_idle);
		int stop_at;
		int pick;
		int plen;
		int tlen;
		int mid;
		bit small_set;
		logic [SYM_BITS-1:0] sym;
		logic [SYM_BITS-1:0] pat_q [$];
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			if (allow_idle) begin
				pick = $urandom_range(0, 2);
				in_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 45;
				pick = $urandom_range(0, 2);
				out_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 45;
			end else begin
				in_gap_pct    = 0;
				out_stall_pct = 0;
			end
			small_set = 1'($urandom_range(0, 1));
			pick = $urandom_range(0, 99);
			// noise: any field combination
			if (pick < 10) begin
				repeat ($urandom_range(1, 6))
					send_request(1'($urandom_range(0, 1)), SYM_BITS'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				continue;
			end
			plen = (pick < 16) ? $urandom_range(60, 70) : $urandom_range(0, 10);
			if (plen > 0)
				pat_q.delete();
			for (int k = 0; k < plen; k++) begin
				sym = small_set ? SYM_BITS'(8'h41 + $urandom_range(0, 3)) :
					SYM_BITS'($urandom_range(0, 255));
				pat_q.push_back(sym);
				send_request(MODE_PATTERN, sym, k == 0, $urandom_range(0, 7) == 0);
			end
			tlen = $urandom_range(1, 20);
			mid = tlen / 2;
			for (int k = 0; k < tlen; k++) begin
				// pattern grows in the middle of the text
				if (pick >= 26 && pick < 30 && k == mid)
					send_request(MODE_PATTERN, SYM_BITS'($urandom_range(0, 255)), 1'b0, 1'b0);
				if (pat_q.size() > 0 && $urandom_range(0, 99) < 60)
					sym = pat_q[k % pat_q.size()];
				else
					sym = small_set ? SYM_BITS'(8'h41 + $urandom_range(0, 3)) :
						SYM_BITS'($urandom_range(0, 255));
				send_request(MODE_TEXT, sym, (k == 0) && !(pick >= 16 && pick < 21),
					(k == tlen - 1) && !(pick >= 21 && pick < 26));
			end
		end
	endtask

	// reset, tests in turn, drain and verdict
	initial begin
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		mode          <= MODE_PATTERN;
		symbol        <= '0;
		first         <= 1'b0;
		last          <= 1'b0;
		pat_len       = 0;
		pat_ovf       = 1'b0;
		for (int j = 0; j <= PAT_CAP; j++)
			row_cost[j] = 0;
		items_sent      = 0;
		in_gap_pct      = 0;
		out_stall_pct   = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_pattern_full();
		test_random_sequences(1500, 1'b1);
		test_random_sequences(100, 1'b0);

		in_valid <= 1'b0;
		while (expected_distances.size() != 0)
			@(posedge clk);
		repeat (PAT_CAP + 8) @(posedge clk);

		$display("%0d requests sent, %0d distances checked (%0d with overflow set)",
			items_sent, results_checked, ovf_results);
		$display("covered empty and full patterns, restarts, unmarked texts,"
			, " mid-text pattern loads; %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("levenshtein_edit_distance: match");
		else
			$display("levenshtein_edit_distance: mismatch");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/led_pkg.sv
hdl/led_cell.sv
hdl/led_head.sv
hdl/levenshtein_edit_distance.sv
bench/levenshtein_edit_distance_test.sv
